[rtl/bc3n_pkg.sv]
// ----------------------------------------------------------------------------
// bc3n_pkg
// Shared types, constants and arithmetic helpers for the BC3 normal map to
// BC7 mode 5 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bc3n_pkg;

  typedef struct packed {
    logic        last_block;
    logic [63:0] color_half;
    logic [63:0] alpha_half;
  } src_t;

  typedef struct packed {
    logic        end_of_run;
    logic [63:0] bc7_high;
    logic [63:0] bc7_low;
  } result_t;

  // bc7 mode 5 header and fixed channels
  localparam logic [5:0] BC7_MODE5  = 6'b100000;
  localparam logic [1:0] BC7_ROT    = 2'b00;
  localparam logic [6:0] RED_END    = 7'd127;
  localparam logic [6:0] BLUE_END   = 7'd0;

  // 2-bit interpolation weights
  localparam logic [6:0] W_ONE      = 7'd21;
  localparam logic [6:0] W_TWO      = 7'd43;
  localparam logic [6:0] W_FULL     = 7'd64;
  localparam logic [6:0] W_ROUND    = 7'd32;

  // cycles from an accepted start to the done strobe
  localparam int PIPE_DEPTH = 5;

  // truncating divide of a value below 1792 by 7
  function automatic logic [7:0] div7(input logic [10:0] n);
    logic [22:0] p;
    p = 23'(n) * 23'd2341;
    return p[21:14];
  endfunction

  // truncating divide of a value below 1280 by 5
  function automatic logic [7:0] div5(input logic [10:0] n);
    logic [22:0] p;
    p = 23'(n) * 23'd3277;
    return p[21:14];
  endfunction

  // truncating divide of a value below 768 by 3
  function automatic logic [7:0] div3(input logic [9:0] n);
    logic [19:0] p;
    p = 20'(n) * 20'd683;
    return p[18:11];
  endfunction

  // g6 * 255 / 63, which is 4*g6 + g6/21
  function automatic logic [7:0] g_expand(input logic [5:0] g6);
    logic [1:0] third;
    if (g6 >= 6'd63) begin
      third = 2'd3;
    end else if (g6 >= 6'd42) begin
      third = 2'd2;
    end else if (g6 >= 6'd21) begin
      third = 2'd1;
    end else begin
      third = 2'd0;
    end
    return {g6, 2'b00} + {6'd0, third};
  endfunction

  // (lo*wlo + hi*whi + 32) >> 6
  function automatic logic [7:0] interp(input logic [7:0] lo, input logic [7:0] hi,
                                        input logic [6:0] wlo, input logic [6:0] whi);
    logic [13:0] s;
    s = 14'(lo) * 14'(wlo) + 14'(hi) * 14'(whi) + 14'(W_ROUND);
    return s[13:6];
  endfunction

endpackage

`default_nettype wire

[rtl/bc3n_fit.sv]
// ----------------------------------------------------------------------------
// bc3n_fit
// Picks the nearest of four interpolated levels for sixteen texels and flips
// all indices and raises swap when the anchor texel lands in the upper half.
// ----------------------------------------------------------------------------
`default_nettype none

module bc3n_fit
  import bc3n_pkg::*;
(
  input  logic [15:0][7:0] vals,
  input  logic [7:0]       lo,
  input  logic [7:0]       hi,
  output logic [15:0][1:0] idx,
  output logic             swap
);

  logic [3:0][7:0]  level;
  logic [15:0][1:0] pick;

  always_comb begin
    level[0] = lo;
    level[1] = interp(lo, hi, W_TWO, W_ONE);
    level[2] = interp(lo, hi, W_ONE, W_TWO);
    level[3] = hi;
  end

  always_comb begin
    logic [7:0] err;
    logic [7:0] best;
    for (int t = 0; t < 16; t++) begin
      best    = (vals[t] > level[0]) ? vals[t] - level[0] : level[0] - vals[t];
      pick[t] = 2'd0;
      for (int i = 1; i < 4; i++) begin
        err = (vals[t] > level[i]) ? vals[t] - level[i] : level[i] - vals[t];
        if (err < best) begin
          best    = err;
          pick[t] = 2'(i);
        end
      end
    end
  end

  // anchor must fit in one bit
  assign swap = pick[0][1];

  always_comb begin
    for (int t = 0; t < 16; t++) begin
      idx[t] = swap ? ~pick[t] : pick[t];
    end
  end

endmodule

`default_nettype wire

[rtl/bc3_normal_to_bc7_transcoder_top.sv]
// ----------------------------------------------------------------------------
// bc3_normal_to_bc7_transcoder_top
// Converts one BC3 normal map block into one BC7 mode 5 block per transfer.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------
//   source    | start / busy         | src    (alpha_half, color_half, last)
//   result    | done (strobe)        | result (bc7_low, bc7_high, end_of_run)
//
// Five-stage pipeline: input register, palette sums, texel decode,
// min/max tree, index fit into the result register.
// One block per cycle outside reset; done follows accepted starts via v0-v3.
// busy is high only while rst is high; otherwise every start is taken.
// Synchronous reset clears the stage valid bits and drops blocks in flight.
// The result is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module bc3_normal_to_bc7_transcoder_top
  import bc3n_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  src_t    src,
  output logic    done,
  output result_t result
);

  // stage 0: input register
  logic v0;
  src_t s0;

  // stage 1: palette sums
  logic              v1;
  logic [5:0][10:0]  s1_n7;
  logic [3:0][10:0]  s1_n5;
  logic [7:0]        s1_a0;
  logic [7:0]        s1_a1;
  logic              s1_a_gt;
  logic [47:0]       s1_asel;
  logic [7:0]        s1_g0;
  logic [7:0]        s1_g1;
  logic [9:0]        s1_n3a;
  logic [9:0]        s1_n3b;
  logic [8:0]        s1_nhalf;
  logic              s1_c_gt;
  logic [31:0]       s1_gsel;
  logic              s1_last;

  // stage 2: texel values
  logic              v2;
  logic [15:0][7:0]  s2_x;
  logic [15:0][7:0]  s2_y;
  logic              s2_last;

  // stage 3: endpoints
  logic              v3;
  logic [15:0][7:0]  s3_x;
  logic [15:0][7:0]  s3_y;
  logic [6:0]        s3_glo;
  logic [6:0]        s3_ghi;
  logic [7:0]        s3_alo;
  logic [7:0]        s3_ahi;
  logic              s3_last;

  logic accept;

  assign busy   = rst;
  assign accept = start && !busy;

  // ---------------------------------------------------------------- stage 1
  logic [5:0][10:0] n7_next;
  logic [3:0][10:0] n5_next;
  logic [7:0]       g0_next;
  logic [7:0]       g1_next;

  always_comb begin
    for (int k = 1; k <= 6; k++) begin
      n7_next[k-1] = 11'(s0.alpha_half[7:0]) * 11'(7 - k)
                   + 11'(s0.alpha_half[15:8]) * 11'(k);
    end
    for (int k = 1; k <= 4; k++) begin
      n5_next[k-1] = 11'(s0.alpha_half[7:0]) * 11'(5 - k)
                   + 11'(s0.alpha_half[15:8]) * 11'(k);
    end
    g0_next = g_expand(s0.color_half[10:5]);
    g1_next = g_expand(s0.color_half[26:21]);
  end

  // ---------------------------------------------------------------- stage 2
  logic [7:0][7:0]  apal;
  logic [3:0][7:0]  gpal;
  logic [15:0][7:0] x_next;
  logic [15:0][7:0] y_next;

  always_comb begin
    apal[0] = s1_a0;
    apal[1] = s1_a1;
    if (s1_a_gt) begin
      for (int k = 0; k < 6; k++) begin
        apal[2+k] = div7(s1_n7[k]);
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        apal[2+k] = div5(s1_n5[k]);
      end
      apal[6] = 8'd0;
      apal[7] = 8'd255;
    end
    gpal[0] = s1_g0;
    gpal[1] = s1_g1;
    if (s1_c_gt) begin
      gpal[2] = div3(s1_n3a);
      gpal[3] = div3(s1_n3b);
    end else begin
      gpal[2] = s1_nhalf[8:1];
      gpal[3] = 8'd0;
    end
    for (int t = 0; t < 16; t++) begin
      x_next[t] = apal[s1_asel[3*t +: 3]];
      y_next[t] = gpal[s1_gsel[2*t +: 2]];
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic [7:0][7:0] xmin1, xmax1, ymin1, ymax1;
  logic [3:0][7:0] xmin2, xmax2, ymin2, ymax2;
  logic [1:0][7:0] xmin3, xmax3, ymin3, ymax3;
  logic [7:0]      xmin4, xmax4, ymin4, ymax4;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      xmin1[i] = (s2_x[2*i] < s2_x[2*i+1]) ? s2_x[2*i] : s2_x[2*i+1];
      xmax1[i] = (s2_x[2*i] > s2_x[2*i+1]) ? s2_x[2*i] : s2_x[2*i+1];
      ymin1[i] = (s2_y[2*i] < s2_y[2*i+1]) ? s2_y[2*i] : s2_y[2*i+1];
      ymax1[i] = (s2_y[2*i] > s2_y[2*i+1]) ? s2_y[2*i] : s2_y[2*i+1];
    end
    for (int i = 0; i < 4; i++) begin
      xmin2[i] = (xmin1[2*i] < xmin1[2*i+1]) ? xmin1[2*i] : xmin1[2*i+1];
      xmax2[i] = (xmax1[2*i] > xmax1[2*i+1]) ? xmax1[2*i] : xmax1[2*i+1];
      ymin2[i] = (ymin1[2*i] < ymin1[2*i+1]) ? ymin1[2*i] : ymin1[2*i+1];
      ymax2[i] = (ymax1[2*i] > ymax1[2*i+1]) ? ymax1[2*i] : ymax1[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      xmin3[i] = (xmin2[2*i] < xmin2[2*i+1]) ? xmin2[2*i] : xmin2[2*i+1];
      xmax3[i] = (xmax2[2*i] > xmax2[2*i+1]) ? xmax2[2*i] : xmax2[2*i+1];
      ymin3[i] = (ymin2[2*i] < ymin2[2*i+1]) ? ymin2[2*i] : ymin2[2*i+1];
      ymax3[i] = (ymax2[2*i] > ymax2[2*i+1]) ? ymax2[2*i] : ymax2[2*i+1];
    end
    xmin4 = (xmin3[0] < xmin3[1]) ? xmin3[0] : xmin3[1];
    xmax4 = (xmax3[0] > xmax3[1]) ? xmax3[0] : xmax3[1];
    ymin4 = (ymin3[0] < ymin3[1]) ? ymin3[0] : ymin3[1];
    ymax4 = (ymax3[0] > ymax3[1]) ? ymax3[0] : ymax3[1];
  end

  // ---------------------------------------------------------------- stage 4
  logic [15:0][1:0] gidx;
  logic [15:0][1:0] aidx;
  logic             gswap;
  logic             aswap;
  logic [6:0]       g_end0;
  logic [6:0]       g_end1;
  logic [7:0]       a_end0;
  logic [7:0]       a_end1;
  logic [127:0]     packed_blk;

  bc3n_fit u_fit_green (
    .vals (s3_y),
    .lo   ({s3_glo, s3_glo[6]}),
    .hi   ({s3_ghi, s3_ghi[6]}),
    .idx  (gidx),
    .swap (gswap)
  );

  bc3n_fit u_fit_alpha (
    .vals (s3_x),
    .lo   (s3_alo),
    .hi   (s3_ahi),
    .idx  (aidx),
    .swap (aswap)
  );

  always_comb begin
    g_end0 = gswap ? s3_ghi : s3_glo;
    g_end1 = gswap ? s3_glo : s3_ghi;
    a_end0 = aswap ? s3_ahi : s3_alo;
    a_end1 = aswap ? s3_alo : s3_ahi;
    packed_blk = {aidx[15:1], aidx[0][0], gidx[15:1], gidx[0][0],
                  a_end1, a_end0, BLUE_END, BLUE_END, g_end1, g_end0,
                  RED_END, RED_END, BC7_ROT, BC7_MODE5};
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= accept;
      v1   <= v0;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0 <= src;
    end

    s1_n7    <= n7_next;
    s1_n5    <= n5_next;
    s1_a0    <= s0.alpha_half[7:0];
    s1_a1    <= s0.alpha_half[15:8];
    s1_a_gt  <= s0.alpha_half[7:0] > s0.alpha_half[15:8];
    s1_asel  <= s0.alpha_half[63:16];
    s1_g0    <= g0_next;
    s1_g1    <= g1_next;
    s1_n3a   <= {1'b0, g0_next, 1'b0} + 10'(g1_next) + 10'd1;
    s1_n3b   <= 10'(g0_next) + {1'b0, g1_next, 1'b0} + 10'd1;
    s1_nhalf <= 9'(g0_next) + 9'(g1_next) + 9'd1;
    s1_c_gt  <= s0.color_half[15:0] > s0.color_half[31:16];
    s1_gsel  <= s0.color_half[63:32];
    s1_last  <= s0.last_block;

    s2_x    <= x_next;
    s2_y    <= y_next;
    s2_last <= s1_last;

    s3_x    <= s2_x;
    s3_y    <= s2_y;
    s3_glo  <= ymin4[7:1];
    s3_ghi  <= ymax4[7:1];
    s3_alo  <= xmin4;
    s3_ahi  <= xmax4;
    s3_last <= s2_last;

    result.bc7_low    <= packed_blk[63:0];
    result.bc7_high   <= packed_blk[127:64];
    result.end_of_run <= s3_last;
  end

endmodule

`default_nettype wire

[rtl/bc3n_checker.sv]
// ----------------------------------------------------------------------------
// bc3n_checker
// Port-level checks on the transcoder: transfer timing and fixed fields of
// every BC7 result.
// ----------------------------------------------------------------------------
`default_nettype none

module bc3n_checker
  import bc3n_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input src_t    src,
  input logic    done,
  input result_t result
);

  // every accepted block comes out after the pipeline delay
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_DEPTH done)
    else $error("accepted block produced no result");

  // no result without a matching transfer in
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_DEPTH))
    else $error("result without accepted block");

  // end marker follows its block
  a_end_marker: assert property (@(posedge clk) disable iff (rst)
    done |-> result.end_of_run == $past(src.last_block, PIPE_DEPTH))
    else $error("end_of_run does not match last_block");

  // mode 5 header and constant red/blue endpoints
  a_fixed_fields: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.bc7_low[7:0] == {BC7_ROT, BC7_MODE5}) &&
             (result.bc7_low[21:8] == {RED_END, RED_END}) &&
             (result.bc7_low[49:36] == {BLUE_END, BLUE_END}))
    else $error("fixed BC7 fields corrupted");

endmodule

bind bc3_normal_to_bc7_transcoder_top bc3n_checker u_bc3n_checker (.*);

`default_nettype wire

[sim/tb_bc3_normal_to_bc7_transcoder_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bc3_normal_to_bc7_transcoder_top
// Self-checking bench for the BC3 normal map to BC7 mode 5 transcoder. A
// behavioral model decodes each accepted source block, fits both channels
// and packs the expected mode 5 block; a small scoreboard compares every
// done strobe against the oldest prediction. Directed corner blocks run
// first, then random blocks under several sender idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none

import bc3n_pkg::*;

typedef int unsigned texel_vals_t [16];

localparam int unsigned FIT_WEIGHT [4] = '{0, 21, 43, 64};
localparam logic [5:0]  MODE5_HDR      = 6'h20;

function automatic int unsigned q7(input int unsigned v);
  int unsigned q;
  q = (v * 127 + 127) / 255;
  return (q > 127) ? 127 : q;
endfunction

function automatic int unsigned widen7(input int unsigned e);
  return ((e << 1) | (e >> 6)) & 32'hff;
endfunction

// nearest weight per texel, then flip so the anchor index fits in 1 bit
function automatic void fit_channel(input texel_vals_t vals, inout int unsigned lo,
                                    inout int unsigned hi, output texel_vals_t idx,
                                    input bit seven);
  int unsigned dl, dh, best, v, err, sw;
  dl = seven ? widen7(lo) : lo;
  dh = seven ? widen7(hi) : hi;
  for (int t = 0; t < 16; t++) begin
    best = 32'hffff_ffff;
    idx[t] = 0;
    for (int i = 0; i < 4; i++) begin
      v = (dl * (64 - FIT_WEIGHT[i]) + dh * FIT_WEIGHT[i] + 32) >> 6;
      err = (v > vals[t]) ? v - vals[t] : vals[t] - v;
      if (err < best) begin
        best = err;
        idx[t] = i;
      end
    end
  end
  if (idx[0] >= 2) begin
    sw = lo;
    lo = hi;
    hi = sw;
    for (int t = 0; t < 16; t++) idx[t] = 3 - idx[t];
  end
endfunction

function automatic void push_bits(inout logic [127:0] w, inout int pos,
                                  input int unsigned v, input int n);
  for (int i = 0; i < n; i++) begin
    if (pos < 128) w[pos] = v[i];
    pos++;
  end
endfunction

function automatic result_t predict_bc7(input src_t s);
  int unsigned a0, a1, c0, c1, g0, g1;
  int unsigned apal [8];
  int unsigned gpal [4];
  texel_vals_t xv, yv, gi, ai;
  int unsigned glo, ghi, alo, ahi;
  logic [127:0] w;
  int pos;
  result_t r;
  a0 = 32'(s.alpha_half[7:0]);
  a1 = 32'(s.alpha_half[15:8]);
  c0 = 32'(s.color_half[15:0]);
  c1 = 32'(s.color_half[31:16]);
  apal[0] = a0;
  apal[1] = a1;
  if (a0 > a1) begin
    for (int k = 1; k <= 6; k++) apal[1 + k] = ((7 - k) * a0 + k * a1) / 7;
  end else begin
    for (int k = 1; k <= 4; k++) apal[1 + k] = ((5 - k) * a0 + k * a1) / 5;
    apal[6] = 0;
    apal[7] = 255;
  end
  for (int t = 0; t < 16; t++) xv[t] = apal[s.alpha_half[16 + 3 * t +: 3]];
  g0 = ((c0 >> 5) & 63) * 255 / 63;
  g1 = ((c1 >> 5) & 63) * 255 / 63;
  gpal[0] = g0;
  gpal[1] = g1;
  if (c0 > c1) begin
    gpal[2] = (2 * g0 + g1 + 1) / 3;
    gpal[3] = (g0 + 2 * g1 + 1) / 3;
  end else begin
    gpal[2] = (g0 + g1 + 1) / 2;
    gpal[3] = 0;
  end
  for (int t = 0; t < 16; t++) yv[t] = gpal[s.color_half[32 + 2 * t +: 2]];
  glo = 255;
  ghi = 0;
  alo = 255;
  ahi = 0;
  for (int t = 0; t < 16; t++) begin
    if (yv[t] < glo) glo = yv[t];
    if (yv[t] > ghi) ghi = yv[t];
    if (xv[t] < alo) alo = xv[t];
    if (xv[t] > ahi) ahi = xv[t];
  end
  g0 = q7(glo);
  g1 = q7(ghi);
  fit_channel(yv, g0, g1, gi, 1'b1);
  fit_channel(xv, alo, ahi, ai, 1'b0);
  w = '0;
  pos = 0;
  push_bits(w, pos, 32'(MODE5_HDR), 6);
  push_bits(w, pos, 0, 2);
  push_bits(w, pos, q7(255), 7);
  push_bits(w, pos, q7(255), 7);
  push_bits(w, pos, g0, 7);
  push_bits(w, pos, g1, 7);
  push_bits(w, pos, q7(0), 7);
  push_bits(w, pos, q7(0), 7);
  push_bits(w, pos, alo, 8);
  push_bits(w, pos, ahi, 8);
  push_bits(w, pos, gi[0], 1);
  for (int t = 1; t < 16; t++) push_bits(w, pos, gi[t], 2);
  push_bits(w, pos, ai[0], 1);
  for (int t = 1; t < 16; t++) push_bits(w, pos, ai[t], 2);
  r.bc7_low = w[63:0];
  r.bc7_high = w[127:64];
  r.end_of_run = s.last_block;
  return r;
endfunction

class bc7_scoreboard;
  result_t block_q[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  function void note_block(input src_t s);
    block_q = {block_q, predict_bc7(s)};
  endfunction

  function void check_result(input result_t got);
    result_t want;
    if (block_q.size() == 0) begin
      $error("result with no block pending: %h", got);
      errors++;
      return;
    end
    want = block_q.pop_front();
    if (got.bc7_low !== want.bc7_low) begin
      $error("bc7_low expected %h actual %h", want.bc7_low, got.bc7_low);
      errors++;
    end
    if (got.bc7_high !== want.bc7_high) begin
      $error("bc7_high expected %h actual %h", want.bc7_high, got.bc7_high);
      errors++;
    end
    if (got.end_of_run !== want.end_of_run) begin
      $error("end_of_run expected %b actual %b", want.end_of_run, got.end_of_run);
      errors++;
    end
  endfunction

  function int pending();
    return block_q.size();
  endfunction
endclass

module tb_bc3_normal_to_bc7_transcoder_top;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  src_t    src;
  logic    done;
  result_t result;

  bc7_scoreboard sb;

  bc3_normal_to_bc7_transcoder_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .src    (src),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // watch both sides at every edge
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_block(src);
      if (done) sb.check_result(result);
    end
  end

  function automatic src_t mk_block(input logic [7:0] a0, input logic [7:0] a1,
                                    input logic [47:0] asel, input logic [15:0] c0,
                                    input logic [15:0] c1, input logic [31:0] csel,
                                    input logic last);
    src_t s;
    s.alpha_half = {asel, a1, a0};
    s.color_half = {csel, c1, c0};
    s.last_block = last;
    return s;
  endfunction

  function automatic src_t rand_block();
    src_t s;
    logic [7:0] t8;
    logic [15:0] t16;
    logic [2:0] as;
    logic [1:0] cs;
    s.alpha_half = {$urandom, $urandom};
    s.color_half = {$urandom, $urandom};
    s.last_block = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      1: begin
        // six-value alpha mode
        if (s.alpha_half[7:0] > s.alpha_half[15:8]) begin
          t8 = s.alpha_half[7:0];
          s.alpha_half[7:0] = s.alpha_half[15:8];
          s.alpha_half[15:8] = t8;
        end
      end
      2: begin
        // three-color mode
        if (s.color_half[15:0] > s.color_half[31:16]) begin
          t16 = s.color_half[15:0];
          s.color_half[15:0] = s.color_half[31:16];
          s.color_half[31:16] = t16;
        end
      end
      3: begin
        // flat selectors, endpoints left random
        as = 3'($urandom);
        cs = 2'($urandom);
        s.alpha_half[63:16] = {16{as}};
        s.color_half[63:32] = {16{cs}};
      end
      4: begin
        // close endpoints
        s.alpha_half[15:8] = s.alpha_half[7:0] + 8'($urandom_range(0, 3));
        s.color_half[31:16] = s.color_half[15:0] + 16'($urandom_range(0, 40));
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  // hold start until the transfer is taken, then optionally go idle
  task automatic send_block(input src_t s, input int gap);
    start <= 1'b1;
    src <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  int idle_pct [4] = '{0, 81, 0, 29};
  int gap;

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    src = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_block(mk_block(8'h00, 8'h00, '0, 16'h0000, 16'h0000, '0, 1'b0), 0);
    send_block(mk_block(8'hff, 8'hff, '1, 16'hffff, 16'hffff, '1, 1'b1), 0);
    send_block(mk_block(8'hff, 8'h00, 48'h000000fac688, 16'hffe0, 16'h0000,
                        32'he4e4e4e4, 1'b0), 0);
    send_block(mk_block(8'h00, 8'hff, 48'hfac688fac688, 16'h0000, 16'hffe0,
                        32'he4e4e4e4, 1'b1), 0);
    send_block(mk_block(8'h40, 8'hc0, {16{3'd6}}, 16'h07e0, 16'h07e0, '0, 1'b0), 2);
    send_block(mk_block(8'h40, 8'hc0, {16{3'd7}}, 16'h07e0, 16'h0000, '1, 1'b0), 0);
    send_block(mk_block(8'h80, 8'h80, 48'h123456789abc, 16'h1234, 16'h1234,
                        32'hffffffff, 1'b1), 0);
    send_block(mk_block(8'h10, 8'hc8, {{15{3'd0}}, 3'd1}, 16'h0000, 16'hffe0,
                        {{15{2'd0}}, 2'd1}, 1'b0), 0);
    send_block(mk_block(8'hc8, 8'h10, {{15{3'd1}}, 3'd0}, 16'hffe0, 16'h0000,
                        {{15{2'd1}}, 2'd0}, 1'b0), 1);
    send_block(mk_block(8'hc8, 8'h10, {{15{3'd0}}, 3'd1}, 16'hffe0, 16'h0000,
                        {{15{2'd0}}, 2'd1}, 1'b1), 0);
    send_block(mk_block(8'h05, 8'h06, 48'h555555555555, 16'h02a0, 16'h0540,
                        32'h1b1b1b1b, 1'b0), 0);
    send_block(mk_block(8'h7f, 8'h01, 48'hffffff000000, 16'h0540, 16'h02a0,
                        32'hf0f0f0f0, 1'b0), 0);
    send_block(mk_block(8'h01, 8'h00, 48'h000000ffffff, 16'h001f, 16'h0020,
                        32'h0f0f0f0f, 1'b1), 3);
    send_block(mk_block(8'h00, 8'h01, 48'hb6db6db6db6d, 16'hf81f, 16'h07e0,
                        32'haaaaaaaa, 1'b0), 0);
    send_block(mk_block(8'hfe, 8'hff, 48'h249249249249, 16'h07e0, 16'hf81f,
                        32'h55555555, 1'b1), 0);
    send_block(mk_block(8'hff, 8'hfe, {16{3'd4}}, 16'h0020, 16'h0000,
                        {16{2'd3}}, 1'b0), 0);
    send_block(mk_block(8'h00, 8'hff, {16{3'd2}}, 16'h0000, 16'h0020,
                        {16{2'd2}}, 1'b0), 0);
    send_block(mk_block(8'h33, 8'hcc, 48'h0, 16'h0fe0, 16'h07c0,
                        32'h3, 1'b1), 0);
    drain();

    // random blocks under each idle mix
    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < 100; n++) begin
        gap = ($urandom_range(0, 99) < idle_pct[ph]) ? $urandom_range(1, 6) : 0;
        send_block(rand_block(), gap);
      end
      drain();
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end

    drain();
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
